FILE: hw/rtl/csbfc_pkg.sv
// Shared constants and types for the clip-space box frustum cull block.
`default_nettype none

package csbfc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  localparam int N_ROWS   = 4;
  localparam int N_COLS   = 4;
  localparam int N_EXT    = 3;
  localparam int N_REGS   = 8;
  localparam int N_PLANES = 5;

  localparam int WORD_W  = 32;
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 6;
  localparam int REG_LSB = 3;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  typedef enum logic [2:0] {
    PL_LEFT,
    PL_RIGHT,
    PL_BOTTOM,
    PL_TOP,
    PL_BACK
  } plane_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csbfc_cfg.sv
// Matrix configuration registers behind the APB-style port.
`default_nettype none

module csbfc_cfg
  import csbfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [PADDR_W-1:0]                          paddr,
  input  logic [PDATA_W-1:0]                          pwdata,
  output logic [PDATA_W-1:0]                          prdata,
  output logic                                        pready,
  output logic [N_ROWS*N_COLS-1:0][COORD_WIDTH-1:0]   mat
);

  logic [N_REGS-1:0][PDATA_W-1:0] mat_regs_r;
  logic [PADDR_W-REG_LSB-1:0]     reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[PADDR_W-1:REG_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = mat_regs_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_regs_r <= '0;
    end else if (wr_en) begin
      mat_regs_r[reg_idx] <= pwdata;
    end
  end

  // Each 64-bit register holds two columns of one row; the low word is the even column.
  for (genvar r = 0; r < N_ROWS; r++) begin : g_row
    for (genvar c = 0; c < N_COLS; c++) begin : g_col
      assign mat[r*N_COLS+c] = mat_regs_r[r*2 + c/2][(c%2)*WORD_W +: COORD_WIDTH];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/csbfc_mult.sv
// Input register stage and the matrix product stage.
`default_nettype none

module csbfc_mult
  import csbfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PROD_W = 2 * COORD_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        adv,
  input  logic                                        in_valid,
  input  logic [N_COLS-1:0][COORD_WIDTH-1:0]          center,
  input  logic [N_EXT-1:0][COORD_WIDTH-2:0]           extent,
  input  logic [N_ROWS*N_COLS-1:0][COORD_WIDTH-1:0]   mat,
  output logic                                        prod_v,
  output logic [N_ROWS*N_COLS-1:0][PROD_W-1:0]        cprod,
  output logic [N_ROWS*N_EXT-1:0][PROD_W-1:0]         eprod
);

  logic                                      s1_v_r;
  logic [N_COLS-1:0][COORD_WIDTH-1:0]        ctr_r;
  logic [N_EXT-1:0][COORD_WIDTH-2:0]         ext_r;
  logic                                      s2_v_r;
  logic [N_ROWS*N_COLS-1:0][PROD_W-1:0]      cprod_r;
  logic [N_ROWS*N_EXT-1:0][PROD_W-1:0]       eprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctr_r <= center;
      ext_r <= extent;
    end
  end

  // By linearity a corner's clip vector is the center's image plus or minus
  // each extent's image, so only the center and the three extents are multiplied.
  for (genvar r = 0; r < N_ROWS; r++) begin : g_row
    for (genvar c = 0; c < N_COLS; c++) begin : g_cprod
      always_ff @(posedge clk) begin
        if (adv) begin
          cprod_r[r*N_COLS+c] <= $signed(mat[r*N_COLS+c]) * $signed(ctr_r[c]);
        end
      end
    end
    for (genvar c = 0; c < N_EXT; c++) begin : g_eprod
      always_ff @(posedge clk) begin
        if (adv) begin
          eprod_r[r*N_EXT+c] <= $signed(mat[r*N_COLS+c]) * $signed({1'b0, ext_r[c]});
        end
      end
    end
  end

  assign prod_v = s2_v_r;
  assign cprod  = cprod_r;
  assign eprod  = eprod_r;

endmodule

`default_nettype wire

FILE: hw/rtl/csbfc_reduce.sv
// Row sums, plane combination and the per-plane worst-corner sign test.
`default_nettype none

module csbfc_reduce
  import csbfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PROD_W = 2 * COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  prod_v,
  input  logic [N_ROWS*N_COLS-1:0][PROD_W-1:0]  cprod,
  input  logic [N_ROWS*N_EXT-1:0][PROD_W-1:0]   eprod,
  output logic                                  out_valid,
  output logic                                  out_culled
);

  localparam int PE_W  = PROD_W + 1;
  localparam int RB_W  = PROD_W + 2;
  localparam int PB_W  = PROD_W + 3;
  localparam int TOT_W = PROD_W + 5;

  logic                 s3_v_r;
  logic                 s4_v_r;
  logic                 out_v_r;
  logic                 culled_r;

  logic signed [RB_W-1:0] rb_nxt [N_ROWS];
  logic signed [RB_W-1:0] rb_r   [N_ROWS];
  logic signed [PE_W-1:0] ex     [N_ROWS][N_EXT];
  logic signed [PE_W-1:0] pe_nxt [N_PLANES][N_EXT];
  logic signed [PE_W-1:0] pe_r   [N_PLANES][N_EXT];
  logic signed [PB_W-1:0] rbx    [N_ROWS];
  logic signed [PB_W-1:0] pb_nxt [N_PLANES];
  logic signed [PB_W-1:0] pb_r   [N_PLANES];
  logic        [PE_W-1:0] mag_nxt [N_PLANES][N_EXT];
  logic        [PE_W-1:0] mag_r   [N_PLANES][N_EXT];
  logic        [TOT_W-1:0] tot    [N_PLANES];
  logic [N_PLANES-1:0]  beyond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r  <= prod_v;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // Stage 3: center image per row, and extent images per plane.
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      rb_nxt[r] = '0;
      for (int c = 0; c < N_COLS; c++) begin
        rb_nxt[r] = rb_nxt[r] +
                    $signed({{(RB_W-PROD_W){cprod[r*N_COLS+c][PROD_W-1]}}, cprod[r*N_COLS+c]});
      end
      for (int c = 0; c < N_EXT; c++) begin
        ex[r][c] = $signed({eprod[r*N_EXT+c][PROD_W-1], eprod[r*N_EXT+c]});
      end
    end
    for (int c = 0; c < N_EXT; c++) begin
      pe_nxt[PL_LEFT][c]   = ex[ROW_X][c] + ex[ROW_W][c];
      pe_nxt[PL_RIGHT][c]  = ex[ROW_W][c] - ex[ROW_X][c];
      pe_nxt[PL_BOTTOM][c] = ex[ROW_Y][c] + ex[ROW_W][c];
      pe_nxt[PL_TOP][c]    = ex[ROW_W][c] - ex[ROW_Y][c];
      pe_nxt[PL_BACK][c]   = ex[ROW_Z][c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rb_r <= rb_nxt;
      pe_r <= pe_nxt;
    end
  end

  // Stage 4: plane value at the center, and the magnitude each extent can add.
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      rbx[r] = $signed({rb_r[r][RB_W-1], rb_r[r]});
    end
    pb_nxt[PL_LEFT]   = rbx[ROW_X] + rbx[ROW_W];
    pb_nxt[PL_RIGHT]  = rbx[ROW_W] - rbx[ROW_X];
    pb_nxt[PL_BOTTOM] = rbx[ROW_Y] + rbx[ROW_W];
    pb_nxt[PL_TOP]    = rbx[ROW_W] - rbx[ROW_Y];
    pb_nxt[PL_BACK]   = rbx[ROW_Z];
    for (int p = 0; p < N_PLANES; p++) begin
      for (int c = 0; c < N_EXT; c++) begin
        mag_nxt[p][c] = pe_r[p][c][PE_W-1] ? PE_W'(-pe_r[p][c]) : PE_W'(pe_r[p][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_r  <= pb_nxt;
      mag_r <= mag_nxt;
    end
  end

  // Stage 5: the worst corner for a plane picks the sign that raises each term,
  // so all corners are beyond the plane exactly when that maximum is negative.
  always_comb begin
    for (int p = 0; p < N_PLANES; p++) begin
      tot[p] = {{(TOT_W-PB_W){pb_r[p][PB_W-1]}}, pb_r[p]};
      for (int c = 0; c < N_EXT; c++) begin
        tot[p] = tot[p] + {{(TOT_W-PE_W){1'b0}}, mag_r[p][c]};
      end
      beyond[p] = tot[p][TOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      culled_r <= |beyond;
    end
  end

  assign out_valid  = out_v_r;
  assign out_culled = culled_r;

endmodule

`default_nettype wire

FILE: hw/rtl/clip_space_box_frustum_cull_core.sv
// Top level of the clip-space box frustum cull pipeline.
`default_nettype none

// Accepts one box per cycle unless the output is stalled and returns one
// culled flag per box. The pipeline is an input register, one product
// stage of 28 parallel multipliers (the matrix times the center and times
// each half extent), a row and plane sum stage, an absolute-value stage and
// a final sign test into the output register. A stall on the output freezes
// every stage at once, so nothing is lost or repeated. The matrix registers
// are read by every box accepted after the write completes; reset clears
// the matrix to zero, which culls nothing.
module clip_space_box_frustum_cull_core
  import csbfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_w,
  input  logic [COORD_WIDTH-2:0]        in_extent_x,
  input  logic [COORD_WIDTH-2:0]        in_extent_y,
  input  logic [COORD_WIDTH-2:0]        in_extent_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_culled,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  localparam int PROD_W = 2 * COORD_WIDTH;

  logic [N_ROWS*N_COLS-1:0][COORD_WIDTH-1:0] mat;
  logic [N_ROWS*N_COLS-1:0][PROD_W-1:0]      cprod;
  logic [N_ROWS*N_EXT-1:0][PROD_W-1:0]       eprod;
  logic                                      prod_v;
  logic                                      adv;

  // The whole pipeline moves unless a finished result is waiting.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  csbfc_cfg #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat     (mat)
  );

  csbfc_mult #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .center   ({in_center_w, in_center_z, in_center_y, in_center_x}),
    .extent   ({in_extent_z, in_extent_y, in_extent_x}),
    .mat      (mat),
    .prod_v   (prod_v),
    .cprod    (cprod),
    .eprod    (eprod)
  );

  csbfc_reduce #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .prod_v     (prod_v),
    .cprod      (cprod),
    .eprod      (eprod),
    .out_valid  (out_valid),
    .out_culled (out_culled)
  );

  // A request that is accepted and then meets no stall comes out as a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
    |=> out_valid)
    else $error("accepted box did not reach the output after five advancing cycles");

  // While stalled, the product stage holds its occupancy and the result stays up.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(prod_v) && out_valid)
    else $error("pipeline moved while the output was stalled");

  // A stall is only raised when a result is actually waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire
